// File: hw/rtl/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg - shared definitions for the multi-stack unit
// Command, status and register index codes, reset values, lane control type.
// ----------------------------------------------------------------------------
`default_nettype none

package msa_pkg;

	// build defaults
	localparam int NUM_STACKS_DEF  = 4;
	localparam int STACK_DEPTH_DEF = 8;
	localparam int VALUE_BITS_DEF  = 32;

	// command codes (code 3 behaves as a peek)
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_BAD_ID    = 2'd3;

	// configuration register indexes
	localparam logic REG_STACK_CAPACITY = 1'b0;
	localparam logic REG_STACKS_IN_USE  = 1'b1;

	localparam logic [3:0] CAP_RESET  = 4'd8;
	localparam logic [2:0] USED_RESET = 3'd4;

	// per-lane shift control
	typedef struct packed {
		logic push;
		logic pop;
	} msa_lane_op_t;

endpackage

`default_nettype wire

// File: hw/rtl/multi_stack_shared_array_unit.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_array_unit - several bounded stacks in one cell array
// Push, pop or peek on a selected stack; one result transaction per request.
// ----------------------------------------------------------------------------
// The result of an accepted request enters the output register next cycle.
// Throughput: 1 transaction per cycle while unstalled; each stack is a shift
//   chain whose top sits in cell 0, so no result waits on a storage read.
// s_tready drops only while a result is held and m_tready is low.
// Reset (arst_n low, async): all counts zero, output empty, registers at
//   capacity 8 and 4 stacks in use. Cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stack_shared_array_unit
	import msa_pkg::*;
#(
	parameter int NUM_STACKS  = NUM_STACKS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_wdata,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // cmd[1:0], stack_id[3:2], push_value[35:4], pad
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata    // status[1:0], top_value[33:2], top_valid[34],
	                                    // stack_count[38:35], is_empty[39]
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	// ---------------- configuration registers ----------------
	logic [3:0] stack_capacity_q;
	logic [2:0] stacks_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_capacity_q <= CAP_RESET;
			stacks_in_use_q  <= USED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STACK_CAPACITY: stack_capacity_q <= cfg_wdata;
				REG_STACKS_IN_USE:  stacks_in_use_q  <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// ---------------- request decode ----------------
	logic [1:0]  in_cmd;
	logic [1:0]  in_id;
	logic [31:0] in_val;
	logic [63:0] in_sx;
	logic [VALUE_BITS-1:0] push_data;

	assign in_cmd    = s_tdata[1:0];
	assign in_id     = s_tdata[3:2];
	assign in_val    = s_tdata[35:4];
	// sign-extend, then keep the stored width
	assign in_sx     = {{32{in_val[31]}}, in_val};
	assign push_data = in_sx[VALUE_BITS-1:0];

	logic accept;
	assign accept = s_tvalid && s_tready;

	// ---------------- lanes ----------------
	logic [CNT_W-1:0]      lane_cnt  [NUM_STACKS];
	logic [VALUE_BITS-1:0] lane_top0 [NUM_STACKS];
	logic [VALUE_BITS-1:0] lane_top1 [NUM_STACKS];
	msa_lane_op_t          lane_op   [NUM_STACKS];

	// selected-lane view
	logic                  id_ok;
	logic [CNT_W-1:0]      sel_cnt;
	logic [VALUE_BITS-1:0] sel_top0;
	logic [VALUE_BITS-1:0] sel_top1;
	logic [CMP_W-1:0]      eff_cap;
	logic                  is_push;
	logic                  is_pop;
	logic                  push_ok;
	logic                  pop_ok;
	logic [1:0]            res_status;
	logic [CNT_W-1:0]      new_cnt;
	logic [VALUE_BITS-1:0] new_top;
	logic [63:0]           new_top_wide;
	logic [31:0]           res_top;
	logic [3:0]            res_count;
	logic                  res_valid;
	logic                  res_empty;

	always_comb begin
		sel_cnt  = '0;
		sel_top0 = '0;
		sel_top1 = '0;
		for (int i = 0; i < NUM_STACKS; i++) begin
			if (5'(in_id) == 5'(i)) begin
				sel_cnt  = sel_cnt  | lane_cnt[i];
				sel_top0 = sel_top0 | lane_top0[i];
				sel_top1 = sel_top1 | lane_top1[i];
			end
		end
	end

	always_comb begin
		// capacity clamped to the build depth
		eff_cap = (CMP_W'(stack_capacity_q) < CMP_W'(STACK_DEPTH)) ?
			CMP_W'(stack_capacity_q) : CMP_W'(STACK_DEPTH);
		id_ok   = (5'(in_id) < 5'(stacks_in_use_q)) && (5'(in_id) < 5'(NUM_STACKS));
		is_push = (in_cmd == CMD_PUSH);
		is_pop  = (in_cmd == CMD_POP);
		push_ok = id_ok && is_push && (CMP_W'(sel_cnt) < eff_cap);
		pop_ok  = id_ok && is_pop && (sel_cnt != '0);

		if (!id_ok) begin
			res_status = ST_BAD_ID;
		end else if (is_push && !push_ok) begin
			res_status = ST_OVERFLOW;
		end else if (is_pop && !pop_ok) begin
			res_status = ST_UNDERFLOW;
		end else begin
			res_status = ST_OK;
		end

		if (push_ok) begin
			new_cnt = sel_cnt + CNT_W'(1);
			new_top = push_data;
		end else if (pop_ok) begin
			new_cnt = sel_cnt - CNT_W'(1);
			new_top = sel_top1;
		end else begin
			new_cnt = sel_cnt;
			new_top = sel_top0;
		end
		new_top_wide = 64'(new_top);

		// rejected id reports all-zero fields
		if (!id_ok) begin
			res_top   = '0;
			res_count = '0;
			res_valid = 1'b0;
			res_empty = 1'b0;
		end else begin
			res_valid = (new_cnt != '0);
			res_empty = (new_cnt == '0);
			res_count = 4'(new_cnt);
			res_top   = res_valid ? new_top_wide[31:0] : 32'd0;
		end
	end

	for (genvar i = 0; i < NUM_STACKS; i++) begin : g_lane
		logic sel;
		assign sel             = (5'(in_id) == 5'(i));
		assign lane_op[i].push = accept && push_ok && sel;
		assign lane_op[i].pop  = accept && pop_ok && sel;

		msa_lane #(
			.DEPTH (STACK_DEPTH),
			.VW    (VALUE_BITS),
			.CNT_W (CNT_W)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (lane_op[i]),
			.push_data (push_data),
			.count     (lane_cnt[i]),
			.top0      (lane_top0[i]),
			.top1      (lane_top1[i])
		);
	end

	// ---------------- output register ----------------
	// takes a new result when it is empty or when the old one leaves in the same cycle
	logic        out_valid_q;
	logic [39:0] out_data_q;

	assign s_tready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {res_empty, res_count, res_valid, res_top, res_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ---------------- assertions ----------------
	// a held result must block new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("request taken while result stalled");

	// an in-use stack reports empty exactly when it has no valid top
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] != ST_BAD_ID)) |-> (m_tdata[39] != m_tdata[34]))
		else $error("is_empty and top_valid disagree");

	// rejected stack id carries zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] == ST_BAD_ID)) |-> (m_tdata[39:2] == '0))
		else $error("bad-id result has nonzero fields");

	// an overflow leaves the stack at or above capacity, never empty unless capacity is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] == ST_OVERFLOW) && (stack_capacity_q != 4'd0))
		|-> m_tdata[34])
		else $error("overflow on a stack with no entries");

endmodule

`default_nettype wire

// File: hw/rtl/msa_cell.sv
// ----------------------------------------------------------------------------
// msa_cell - one storage slot of a shift stack
// Loads from the slot above on push, from the slot below on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module msa_cell #(
	parameter int VW = 32
) (
	input  wire logic          clk,
	input  wire logic          shift_dn,
	input  wire logic          shift_up,
	input  wire logic [VW-1:0] from_above,
	input  wire logic [VW-1:0] from_below,
	output logic      [VW-1:0] value
);

	logic [VW-1:0] value_q;

	always_ff @(posedge clk) begin
		if (shift_dn) begin
			value_q <= from_above;
		end else if (shift_up) begin
			value_q <= from_below;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

// File: hw/rtl/msa_lane.sv
// ----------------------------------------------------------------------------
// msa_lane - one stack as a chain of cells
// Cell 0 is the top of stack; a push shifts down, a pop shifts up.
// ----------------------------------------------------------------------------
`default_nettype none

module msa_lane
	import msa_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF,
	parameter int VW    = VALUE_BITS_DEF,
	parameter int CNT_W = $clog2(STACK_DEPTH_DEF + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire msa_lane_op_t     op,
	input  wire logic [VW-1:0]    push_data,
	output logic      [CNT_W-1:0] count,
	output logic      [VW-1:0]    top0,
	output logic      [VW-1:0]    top1
);

	logic [VW-1:0]    val [DEPTH];
	logic [CNT_W-1:0] count_q;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [VW-1:0] above;
		logic [VW-1:0] below;
		if (k == 0) begin : g_first
			assign above = push_data;
		end else begin : g_mid
			assign above = val[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_inner
			assign below = val[k+1];
		end
		msa_cell #(.VW(VW)) u_cell (
			.clk        (clk),
			.shift_dn   (op.push),
			.shift_up   (op.pop),
			.from_above (above),
			.from_below (below),
			.value      (val[k])
		);
	end

	// caller only issues legal pushes and pops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (op.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign count = count_q;
	assign top0  = val[0];

	if (DEPTH > 1) begin : g_top1
		assign top1 = val[1];
	end else begin : g_no_top1
		assign top1 = '0;
	end

endmodule

`default_nettype wire
